[rtl/ppil_pkg.sv]
// ----------------------------------------------------------------------------
// ppil_pkg
// Shared types and constants for the plane pair intersection line block.
// ----------------------------------------------------------------------------
package ppil_pkg;

  localparam int COEF_FRAC_BITS = 16;

  // Point quotient: 32 restoring steps after one range-check stage.
  localparam int PT_STEPS = 32;
  localparam int PT_LAT   = PT_STEPS + 1;

  // Direction: 61 quotient bits of c^2*2^60/S, then a 31-step square root.
  localparam int DIR_DIV_STEPS = 61;
  localparam int SQRT_STEPS    = 31;
  localparam int DIR_LAT       = DIR_DIV_STEPS + 1 + SQRT_STEPS;

  localparam int PT_PAD = DIR_LAT - PT_LAT;

  localparam logic [62:0] PARALLEL_LIMIT_RESET = 63'd18;

  typedef struct packed {
    logic signed [31:0] plane1_a;
    logic signed [31:0] plane1_b;
    logic signed [31:0] plane1_c;
    logic signed [31:0] plane1_d;
    logic signed [31:0] plane2_a;
    logic signed [31:0] plane2_b;
    logic signed [31:0] plane2_c;
    logic signed [31:0] plane2_d;
  } ppil_in_t;

  typedef struct packed {
    logic               unique_line;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
  } ppil_out_t;

  typedef enum logic [1:0] {
    AXIS_X,
    AXIS_Y,
    AXIS_Z
  } axis_t;

  typedef struct packed {
    logic        neg;
    logic [63:0] mag;
  } sm_t;

  typedef struct packed {
    logic       vld;
    logic       uniq;
    axis_t      axis;
    logic       pa_neg;
    logic       pb_neg;
    logic [2:0] dir_neg;
  } ppil_ctl_t;

endpackage

[rtl/ppil_point_div.sv]
// ----------------------------------------------------------------------------
// ppil_point_div
// Two-lane pipelined restoring divider: (num * 2^COEF_FRAC_BITS) / den,
// 32 quotient bits per lane plus an overflow flag, one bit per stage.
// ----------------------------------------------------------------------------
module ppil_point_div (
  input  logic             clk,
  input  logic             adv,
  input  logic [1:0][63:0] num,
  input  logic [63:0]      den,
  output logic [1:0][31:0] quo,
  output logic [1:0]       over
);
  import ppil_pkg::*;

  logic [63:0]      den_r   [PT_STEPS];
  logic [63:0]      den_nxt [PT_STEPS];
  logic [1:0][63:0] rem_r   [PT_STEPS];
  logic [1:0][63:0] rem_nxt [PT_STEPS];
  logic [1:0][31:0] bits_r  [PT_STEPS];
  logic [1:0][31:0] bits_nxt[PT_STEPS];
  logic [1:0][31:0] quo_r   [PT_STEPS+1];
  logic [1:0][31:0] quo_nxt [PT_STEPS+1];
  logic [1:0]       over_r  [PT_STEPS+1];
  logic [1:0]       over_nxt[PT_STEPS+1];

  always_comb begin
    logic [64:0] t;
    logic        ge;
    t  = '0;
    ge = 1'b0;
    // Quotient at or above 2^32 shows up as (num >> frac) >= den.
    den_nxt[0] = den;
    for (int l = 0; l < 2; l++) begin
      rem_nxt[0][l]  = num[l] >> COEF_FRAC_BITS;
      bits_nxt[0][l] = num[l][31:0] << COEF_FRAC_BITS;
      quo_nxt[0][l]  = '0;
      over_nxt[0][l] = (num[l] >> COEF_FRAC_BITS) >= den;
    end
    for (int k = 1; k <= PT_STEPS; k++) begin
      over_nxt[k] = over_r[k-1];
      if (k < PT_STEPS) begin
        den_nxt[k] = den_r[k-1];
      end
      for (int l = 0; l < 2; l++) begin
        t  = {rem_r[k-1][l], bits_r[k-1][l][31]};
        ge = t >= {1'b0, den_r[k-1]};
        quo_nxt[k][l] = {quo_r[k-1][l][PT_STEPS-2:0], ge};
        if (k < PT_STEPS) begin
          rem_nxt[k][l]  = ge ? 64'(t - {1'b0, den_r[k-1]}) : t[63:0];
          bits_nxt[k][l] = bits_r[k-1][l] << 1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < PT_STEPS; k++) begin
        den_r[k]  <= den_nxt[k];
        rem_r[k]  <= rem_nxt[k];
        bits_r[k] <= bits_nxt[k];
      end
      for (int k = 0; k <= PT_STEPS; k++) begin
        quo_r[k]  <= quo_nxt[k];
        over_r[k] <= over_nxt[k];
      end
    end
  end

  assign quo  = quo_r[PT_STEPS];
  assign over = over_r[PT_STEPS];

endmodule

[rtl/ppil_unit_dir.sv]
// ----------------------------------------------------------------------------
// ppil_unit_dir
// Unit direction magnitudes: floor(sqrt(c^2 * 2^60 / S)) for three lanes,
// S being the sum of the three c^2; pipelined divide then square root.
// ----------------------------------------------------------------------------
module ppil_unit_dir (
  input  logic             clk,
  input  logic             adv,
  input  logic [2:0][61:0] csq,
  output logic [2:0][30:0] mag
);
  import ppil_pkg::*;

  logic [63:0]                     s_r      [DIR_DIV_STEPS];
  logic [63:0]                     s_nxt    [DIR_DIV_STEPS];
  logic [2:0][64:0]                rem_r    [DIR_DIV_STEPS];
  logic [2:0][64:0]                rem_nxt  [DIR_DIV_STEPS];
  logic [2:0][DIR_DIV_STEPS-1:0]   q_r      [DIR_DIV_STEPS+1];
  logic [2:0][DIR_DIV_STEPS-1:0]   q_nxt    [DIR_DIV_STEPS+1];
  logic [2:0][DIR_DIV_STEPS-1:0]   srem_r   [1:SQRT_STEPS-1];
  logic [2:0][DIR_DIV_STEPS-1:0]   srem_nxt [1:SQRT_STEPS-1];
  logic [2:0][61:0]                sres_r   [1:SQRT_STEPS];
  logic [2:0][61:0]                sres_nxt [1:SQRT_STEPS];

  always_comb begin
    logic                     ge;
    logic [64:0]              r2;
    logic [DIR_DIV_STEPS-1:0] rin;
    logic [61:0]              res_in;
    logic [61:0]              one;
    logic [61:0]              trial;
    ge     = 1'b0;
    r2     = '0;
    rin    = '0;
    res_in = '0;
    one    = '0;
    trial  = '0;
    s_nxt[0] = 64'(csq[0]) + 64'(csq[1]) + 64'(csq[2]);
    for (int l = 0; l < 3; l++) begin
      rem_nxt[0][l] = 65'(csq[l]);
      q_nxt[0][l]   = '0;
    end
    // Long division: remainder stays below S, so shifting keeps it in 65 bits.
    for (int k = 1; k <= DIR_DIV_STEPS; k++) begin
      if (k < DIR_DIV_STEPS) begin
        s_nxt[k] = s_r[k-1];
      end
      for (int l = 0; l < 3; l++) begin
        ge = rem_r[k-1][l] >= {1'b0, s_r[k-1]};
        r2 = ge ? rem_r[k-1][l] - {1'b0, s_r[k-1]} : rem_r[k-1][l];
        q_nxt[k][l] = {q_r[k-1][l][DIR_DIV_STEPS-2:0], ge};
        if (k < DIR_DIV_STEPS) begin
          rem_nxt[k][l] = {r2[63:0], 1'b0};
        end
      end
    end
    // Digit-by-digit square root, one result bit per stage.
    for (int m = 1; m <= SQRT_STEPS; m++) begin
      one = 62'(1) << (2 * (SQRT_STEPS - m));
      for (int l = 0; l < 3; l++) begin
        if (m == 1) begin
          rin    = q_r[DIR_DIV_STEPS][l];
          res_in = '0;
        end else begin
          rin    = srem_r[m-1][l];
          res_in = sres_r[m-1][l];
        end
        trial = res_in + one;
        ge    = {1'b0, rin} >= trial;
        sres_nxt[m][l] = ge ? (res_in >> 1) + one : res_in >> 1;
        if (m < SQRT_STEPS) begin
          srem_nxt[m][l] = ge ? DIR_DIV_STEPS'({1'b0, rin} - trial) : rin;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < DIR_DIV_STEPS; k++) begin
        s_r[k]   <= s_nxt[k];
        rem_r[k] <= rem_nxt[k];
      end
      for (int k = 0; k <= DIR_DIV_STEPS; k++) begin
        q_r[k] <= q_nxt[k];
      end
      for (int m = 1; m < SQRT_STEPS; m++) begin
        srem_r[m] <= srem_nxt[m];
      end
      for (int m = 1; m <= SQRT_STEPS; m++) begin
        sres_r[m] <= sres_nxt[m];
      end
    end
  end

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      mag[l] = sres_r[SQRT_STEPS][l][30:0];
    end
  end

endmodule

[rtl/plane_pair_intersection_line.sv]
// ----------------------------------------------------------------------------
// plane_pair_intersection_line
// Line where two planes meet: point (Q16.16) and unit direction (Q2.30).
// ----------------------------------------------------------------------------
// Fully pipelined: one plane pair is taken every clock unless the output is
// stalled, and its result word passes six front stages for products, cross
// product, length test and scaling, 93 stages of the direction divide and
// square root, and one output register. The point divides run alongside
// and are delayed to match. The whole pipeline holds while an output word is
// stalled, so in_stall follows out_stall when out_valid is high.
// parallel_limit resets to 18 and may be written whenever the block is idle.
// ----------------------------------------------------------------------------
module plane_pair_intersection_line (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  ppil_pkg::ppil_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output ppil_pkg::ppil_out_t out_data,
  input  logic                cfg_wr_en,
  input  logic [62:0]         cfg_wr_data
);
  import ppil_pkg::*;

  typedef struct packed {
    logic [1:0]       over;
    logic [1:0][31:0] quo;
  } pt_res_t;

  logic        adv;
  logic        out_valid_r;
  ppil_out_t   out_data_r;
  ppil_out_t   out_data_nxt;
  logic [62:0] parallel_limit_r;

  assign adv       = !out_valid_r || !out_stall;
  assign in_stall  = !adv;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      parallel_limit_r <= PARALLEL_LIMIT_RESET;
    end else if (cfg_wr_en) begin
      parallel_limit_r <= cfg_wr_data;
    end
  end

  // Stage 1: products
  logic signed [32:0] a1, b1, c1, d1, a2, b2, c2, d2;
  logic signed [65:0] prod_nxt [12];
  logic signed [65:0] prod_r   [12];

  assign a1 = 33'(in_data.plane1_a);
  assign b1 = 33'(in_data.plane1_b);
  assign c1 = 33'(in_data.plane1_c);
  assign d1 = -33'(in_data.plane1_d);
  assign a2 = 33'(in_data.plane2_a);
  assign b2 = 33'(in_data.plane2_b);
  assign c2 = 33'(in_data.plane2_c);
  assign d2 = -33'(in_data.plane2_d);

  always_comb begin
    prod_nxt[0]  = b1 * c2;
    prod_nxt[1]  = c1 * b2;
    prod_nxt[2]  = c1 * a2;
    prod_nxt[3]  = a1 * c2;
    prod_nxt[4]  = a1 * b2;
    prod_nxt[5]  = b1 * a2;
    prod_nxt[6]  = d1 * c2;
    prod_nxt[7]  = d2 * c1;
    prod_nxt[8]  = b1 * d2;
    prod_nxt[9]  = b2 * d1;
    prod_nxt[10] = a1 * d2;
    prod_nxt[11] = a2 * d1;
  end

  // Stage 2: differences as sign and magnitude (cross x, y, z, then N0..N2)
  sm_t sm_nxt [6];
  sm_t sm_r   [6];

  always_comb begin
    logic signed [66:0] diff;
    diff = '0;
    for (int k = 0; k < 6; k++) begin
      diff = 67'(prod_r[2*k]) - 67'(prod_r[2*k+1]);
      sm_nxt[k].neg = diff[66];
      sm_nxt[k].mag = diff[66] ? 64'(-diff) : 64'(diff);
    end
  end

  // Stage 3: squares, axis choice, divide operands
  logic [63:0] sq3_nxt [3];
  logic [63:0] sq3_r   [3];
  logic        big3_nxt, big3_r, nz3_nxt, nz3_r;
  axis_t       axis3_nxt, axis3_r;
  logic [63:0] mx3_nxt, mx3_r;
  sm_t         den3_nxt, den3_r, na3_nxt, na3_r, nb3_nxt, nb3_r;
  sm_t         crs3_r [3];

  always_comb begin
    logic [63:0] ax, ay, az;
    ax = sm_r[0].mag;
    ay = sm_r[1].mag;
    az = sm_r[2].mag;
    for (int i = 0; i < 3; i++) begin
      sq3_nxt[i] = (sm_r[i].mag[63:32] == '0) ?
                   sm_r[i].mag[31:0] * sm_r[i].mag[31:0] : '0;
    end
    big3_nxt = (ax[63:32] != '0) || (ay[63:32] != '0) || (az[63:32] != '0);
    nz3_nxt  = (ax | ay | az) != '0;
    mx3_nxt  = (ax > ay) ? ax : ay;
    if (az > mx3_nxt) begin
      mx3_nxt = az;
    end
    // Ties go to x, then y.
    if (ax >= ay && ax >= az) begin
      axis3_nxt = AXIS_X;
      den3_nxt  = sm_r[0];
      na3_nxt   = sm_r[3];
      nb3_nxt   = sm_r[4];
    end else if (ay >= az) begin
      axis3_nxt = AXIS_Y;
      den3_nxt  = '{neg: !sm_r[1].neg, mag: sm_r[1].mag};
      na3_nxt   = sm_r[3];
      nb3_nxt   = sm_r[5];
    end else begin
      axis3_nxt = AXIS_Z;
      den3_nxt  = sm_r[2];
      na3_nxt   = '{neg: !sm_r[4].neg, mag: sm_r[4].mag};
      nb3_nxt   = sm_r[5];
    end
  end

  // Stage 4: length sum, scale shift
  logic [65:0] len4_nxt, len4_r;
  logic [5:0]  sh4_nxt, sh4_r;
  logic        big4_r, nz4_r;
  axis_t       axis4_r;
  sm_t         den4_r, na4_r, nb4_r;
  sm_t         crs4_r [3];

  always_comb begin
    len4_nxt = 66'(sq3_r[0]) + 66'(sq3_r[1]) + 66'(sq3_r[2]);
    // Shift until the largest magnitude is below 2^31.
    sh4_nxt = '0;
    for (int j = 31; j < 64; j++) begin
      if (mx3_r[j]) begin
        sh4_nxt = 6'(j - 30);
      end
    end
  end

  // Stage 5: line test, scaled magnitudes
  logic        uniq5_nxt, uniq5_r;
  logic [30:0] red5_nxt [3];
  logic [30:0] red5_r   [3];
  logic [2:0]  neg5_r;
  axis_t       axis5_r;
  sm_t         den5_r, na5_r, nb5_r;

  always_comb begin
    uniq5_nxt = nz4_r && (big4_r || len4_r >= 66'(parallel_limit_r));
    for (int i = 0; i < 3; i++) begin
      red5_nxt[i] = 31'(crs4_r[i].mag >> sh4_r);
    end
  end

  // Stage 6: squares of the scaled magnitudes
  logic [2:0][61:0] rsq6_nxt, rsq6_r;
  logic             uniq6_r;
  logic [2:0]       neg6_r;
  axis_t            axis6_r;
  sm_t              den6_r, na6_r, nb6_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rsq6_nxt[i] = red5_r[i] * red5_r[i];
    end
  end

  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r  <= prod_nxt;
      sm_r    <= sm_nxt;
      sq3_r   <= sq3_nxt;
      big3_r  <= big3_nxt;
      nz3_r   <= nz3_nxt;
      axis3_r <= axis3_nxt;
      mx3_r   <= mx3_nxt;
      den3_r  <= den3_nxt;
      na3_r   <= na3_nxt;
      nb3_r   <= nb3_nxt;
      for (int i = 0; i < 3; i++) begin
        crs3_r[i] <= sm_r[i];
        crs4_r[i] <= crs3_r[i];
        neg5_r[i] <= crs4_r[i].neg;
      end
      len4_r  <= len4_nxt;
      sh4_r   <= sh4_nxt;
      big4_r  <= big3_r;
      nz4_r   <= nz3_r;
      axis4_r <= axis3_r;
      den4_r  <= den3_r;
      na4_r   <= na3_r;
      nb4_r   <= nb3_r;
      uniq5_r <= uniq5_nxt;
      red5_r  <= red5_nxt;
      axis5_r <= axis4_r;
      den5_r  <= den4_r;
      na5_r   <= na4_r;
      nb5_r   <= nb4_r;
      rsq6_r  <= rsq6_nxt;
      uniq6_r <= uniq5_r;
      neg6_r  <= neg5_r;
      axis6_r <= axis5_r;
      den6_r  <= den5_r;
      na6_r   <= na5_r;
      nb6_r   <= nb5_r;
    end
  end

  // Divide and square root pipelines
  logic [1:0][31:0] pt_quo;
  logic [1:0]       pt_over;
  logic [2:0][30:0] dir_mag;

  ppil_point_div u_point_div (
    .clk  (clk),
    .adv  (adv),
    .num  ({nb6_r.mag, na6_r.mag}),
    .den  (den6_r.mag),
    .quo  (pt_quo),
    .over (pt_over)
  );

  ppil_unit_dir u_unit_dir (
    .clk (clk),
    .adv (adv),
    .csq (rsq6_r),
    .mag (dir_mag)
  );

  // Control travels alongside the direction pipeline; point words are padded.
  ppil_ctl_t ctl_in;
  ppil_ctl_t ctl_r [1:DIR_LAT];
  pt_res_t   pad_r [PT_PAD];

  always_comb begin
    ctl_in.vld     = v6_r;
    ctl_in.uniq    = uniq6_r;
    ctl_in.axis    = axis6_r;
    ctl_in.pa_neg  = na6_r.neg ^ den6_r.neg;
    ctl_in.pb_neg  = nb6_r.neg ^ den6_r.neg;
    ctl_in.dir_neg = neg6_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 1; k <= DIR_LAT; k++) begin
        ctl_r[k] <= '0;
      end
    end else if (adv) begin
      ctl_r[1] <= ctl_in;
      for (int k = 2; k <= DIR_LAT; k++) begin
        ctl_r[k] <= ctl_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pad_r[0] <= '{over: pt_over, quo: pt_quo};
      for (int k = 1; k < PT_PAD; k++) begin
        pad_r[k] <= pad_r[k-1];
      end
    end
  end

  function automatic logic [31:0] pt_value(input logic [31:0] q, input logic ov,
                                           input logic neg);
    logic [32:0] lim;
    logic [32:0] m;
    lim = neg ? 33'h0_8000_0000 : 33'h0_7FFF_FFFF;
    m   = (ov || {1'b0, q} > lim) ? lim : {1'b0, q};
    return neg ? 32'(-m) : m[31:0];
  endfunction

  function automatic logic [31:0] dir_value(input logic [30:0] q, input logic neg);
    logic [31:0] d;
    d = {1'b0, q};
    return neg ? -d : d;
  endfunction

  always_comb begin
    ppil_ctl_t   c;
    pt_res_t     p;
    logic [31:0] pa, pb;
    c  = ctl_r[DIR_LAT];
    p  = pad_r[PT_PAD-1];
    pa = pt_value(p.quo[0], p.over[0], c.pa_neg);
    pb = pt_value(p.quo[1], p.over[1], c.pb_neg);
    out_data_nxt = '0;
    if (c.uniq) begin
      out_data_nxt.unique_line = 1'b1;
      out_data_nxt.dir_x = dir_value(dir_mag[0], c.dir_neg[0]);
      out_data_nxt.dir_y = dir_value(dir_mag[1], c.dir_neg[1]);
      out_data_nxt.dir_z = dir_value(dir_mag[2], c.dir_neg[2]);
      case (c.axis)
        AXIS_X: begin
          out_data_nxt.point_y = pa;
          out_data_nxt.point_z = pb;
        end
        AXIS_Y: begin
          out_data_nxt.point_x = pa;
          out_data_nxt.point_z = pb;
        end
        AXIS_Z: begin
          out_data_nxt.point_x = pa;
          out_data_nxt.point_y = pb;
        end
        default: begin
          out_data_nxt.point_x = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= ctl_r[DIR_LAT].vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  a_no_line_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r.unique_line |->
      out_data_r.point_x == 0 && out_data_r.point_y == 0 && out_data_r.point_z == 0 &&
      out_data_r.dir_x == 0 && out_data_r.dir_y == 0 && out_data_r.dir_z == 0)
    else $error("nonzero coordinates without a unique line");

  a_dir_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |->
      out_data_r.dir_x <= 32'sd1073741824 && out_data_r.dir_x >= -32'sd1073741824 &&
      out_data_r.dir_y <= 32'sd1073741824 && out_data_r.dir_y >= -32'sd1073741824 &&
      out_data_r.dir_z <= 32'sd1073741824 && out_data_r.dir_z >= -32'sd1073741824)
    else $error("direction component beyond unit range");

  a_dir_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.unique_line |->
      out_data_r.dir_x != 0 || out_data_r.dir_y != 0 || out_data_r.dir_z != 0)
    else $error("unique line with zero direction");

  a_axis_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.unique_line |->
      out_data_r.point_x == 0 || out_data_r.point_y == 0 || out_data_r.point_z == 0)
    else $error("no point coordinate pinned to zero");

endmodule

[tb/plane_pair_intersection_line_test.sv]
// ----------------------------------------------------------------------------
// plane_pair_intersection_line_test
// Self-checking bench for the plane pair intersection line block: plane pairs
// go in through the input channel, and each result word is checked field by
// field against an in-bench fixed point computation of point and direction.
// ----------------------------------------------------------------------------
module plane_pair_intersection_line_test;
  import ppil_pkg::*;

  localparam int         PIPE_DRAIN   = 110;
  localparam int         WDOG_LIMIT   = 20000;
  localparam int         HOLD_CYCLES  = 400;
  localparam int         IDLE_PCT     = 17;
  localparam logic [62:0] LIMIT_MAX   = 63'h7FFF_FFFF_FFFF_FFFF;
  localparam int         ONE          = 1 << COEF_FRAC_BITS;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  ppil_in_t    in_data;
  logic        out_valid;
  logic        out_stall;
  ppil_out_t   out_data;
  logic        cfg_wr_en;
  logic [62:0] cfg_wr_data;

  logic [62:0] cur_limit;
  ppil_out_t   line_q[$];
  int          mismatches;
  int          words_sent;
  int          words_seen;
  int          unique_seen;
  int          limit_writes;
  bit          calm;
  bit          hold_req;
  bit          hold_done;
  int          hold_left;
  int          quiet_cycles;

  plane_pair_intersection_line u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // a*b - c*d as sign and magnitude
  function automatic void diff_prod(input logic signed [65:0] a, b, c, d,
                                    output logic neg, output logic [63:0] mag);
    logic signed [65:0] r;
    r = a * b - c * d;
    neg = r < 0;
    mag = neg ? 64'(-r) : 64'(r);
  endfunction

  function automatic logic [31:0] point_coord(input logic nneg, input logic [63:0] nmag,
                                              input logic dneg, input logic [63:0] dmag);
    logic [79:0] q;
    logic [79:0] lim;
    logic        neg;
    neg = nneg != dneg;
    q = {nmag, 16'b0} / {16'b0, dmag};
    lim = neg ? 80'h8000_0000 : 80'h7FFF_FFFF;
    if (q > lim) q = lim;
    return neg ? 32'(-q) : 32'(q);
  endfunction

  // largest q below 2^31 with q*q*s <= c*c*2^60
  function automatic logic [31:0] unit_component(input logic [63:0] c, input logic [63:0] s);
    logic [127:0] rhs;
    logic [127:0] lhs;
    logic [31:0]  q;
    logic [31:0]  t;
    rhs = (128'(c) * 128'(c)) << 60;
    q = '0;
    for (int b = 30; b >= 0; b--) begin
      t = q | (32'd1 << b);
      lhs = 128'(t) * 128'(t) * 128'(s);
      if (lhs <= rhs) q = t;
    end
    return q;
  endfunction

  function automatic ppil_out_t predict_line(input ppil_in_t p);
    logic signed [65:0] a1, b1, c1, d1, a2, b2, c2, d2;
    logic        cn[3];
    logic [63:0] cm[3];
    logic        nn0, nn1;
    logic [63:0] nm0, nm1;
    logic [65:0] len2;
    logic [63:0] mx, s;
    logic [63:0] red[3];
    logic [31:0] q;
    bit          big;
    int          shift;
    axis_t       axis;
    ppil_out_t   r;
    a1 = p.plane1_a; b1 = p.plane1_b; c1 = p.plane1_c; d1 = -66'(p.plane1_d);
    a2 = p.plane2_a; b2 = p.plane2_b; c2 = p.plane2_c; d2 = -66'(p.plane2_d);
    r = '0;
    diff_prod(b1, c2, c1, b2, cn[0], cm[0]);
    diff_prod(c1, a2, a1, c2, cn[1], cm[1]);
    diff_prod(a1, b2, b1, a2, cn[2], cm[2]);
    big = 0;
    len2 = 0;
    for (int i = 0; i < 3; i++) begin
      if (cm[i][63:32] != 0) big = 1;
      else begin
        len2 = len2 + 66'(cm[i] * cm[i]);
        if (len2 > 66'h0_FFFF_FFFF_FFFF_FFFF) len2 = 66'h0_FFFF_FFFF_FFFF_FFFF;
      end
    end
    if ((cm[0] | cm[1] | cm[2]) == 0 || !(big || len2 >= 66'(cur_limit))) return r;
    r.unique_line = 1'b1;
    if (cm[0] >= cm[1] && cm[0] >= cm[2]) axis = AXIS_X;
    else if (cm[1] >= cm[2]) axis = AXIS_Y;
    else axis = AXIS_Z;
    case (axis)
      AXIS_X: begin
        diff_prod(d1, c2, d2, c1, nn0, nm0);
        diff_prod(b1, d2, b2, d1, nn1, nm1);
        r.point_y = point_coord(nn0, nm0, cn[0], cm[0]);
        r.point_z = point_coord(nn1, nm1, cn[0], cm[0]);
      end
      AXIS_Y: begin
        diff_prod(d1, c2, d2, c1, nn0, nm0);
        diff_prod(a1, d2, a2, d1, nn1, nm1);
        r.point_x = point_coord(nn0, nm0, !cn[1], cm[1]);
        r.point_z = point_coord(nn1, nm1, !cn[1], cm[1]);
      end
      default: begin
        diff_prod(d1, b2, d2, b1, nn0, nm0);
        diff_prod(a1, d2, a2, d1, nn1, nm1);
        r.point_x = point_coord(nn0, nm0, cn[2], cm[2]);
        r.point_y = point_coord(nn1, nm1, cn[2], cm[2]);
      end
    endcase
    mx = cm[0] > cm[1] ? cm[0] : cm[1];
    if (cm[2] > mx) mx = cm[2];
    shift = 0;
    while ((mx >> shift) >= 64'h8000_0000) shift++;
    s = 0;
    for (int i = 0; i < 3; i++) begin
      red[i] = cm[i] >> shift;
      s = s + red[i] * red[i];
    end
    q = unit_component(red[0], s); r.dir_x = cn[0] ? -q : q;
    q = unit_component(red[1], s); r.dir_y = cn[1] ? -q : q;
    q = unit_component(red[2], s); r.dir_z = cn[2] ? -q : q;
    return r;
  endfunction

  function automatic logic [31:0] rand_span(input int unsigned span);
    return 32'($urandom_range(0, 2 * span)) - 32'(span);
  endfunction

  function automatic ppil_in_t rand_pair(input int kind);
    ppil_in_t p;
    int unsigned span;
    int          k;
    span = ($urandom_range(0, 3) == 0) ? 32'h7FFF_FFFF : (ONE << $urandom_range(0, 4));
    p = {rand_span(span), rand_span(span), rand_span(span), rand_span(span),
         rand_span(span), rand_span(span), rand_span(span), rand_span(span)};
    if (kind == 0) p = {$urandom, $urandom, $urandom, $urandom,
                        $urandom, $urandom, $urandom, $urandom};
    if (kind == 1) begin
      // nearly parallel: scaled copy of the first normal, tiny nudge
      k = $urandom_range(1, 3);
      span = $urandom_range(1, 40000);
      p.plane1_a = rand_span(span); p.plane1_b = rand_span(span);
      p.plane1_c = rand_span(span);
      p.plane2_a = p.plane1_a * k + rand_span($urandom_range(0, 2));
      p.plane2_b = p.plane1_b * k + rand_span($urandom_range(0, 2));
      p.plane2_c = p.plane1_c * k;
    end
    return p;
  endfunction

  task automatic idle_gap();
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic send_pair(input ppil_in_t p);
    idle_gap();
    in_valid <= 1'b1;
    in_data  <= p;
    do @(posedge clk); while (in_stall);
    line_q.push_back(predict_line(p));
    words_sent++;
  endtask

  task automatic write_limit(input logic [62:0] v);
    in_valid <= 1'b0;
    while (line_q.size() != 0) @(posedge clk);
    repeat (PIPE_DRAIN) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cur_limit = v;
    limit_writes++;
  endtask

  task automatic send_planes(input logic signed [31:0] a1, b1, c1, d1, a2, b2, c2, d2);
    send_pair({a1, b1, c1, d1, a2, b2, c2, d2});
  endtask

  task automatic test_directed();
    logic signed [31:0] mn, mxv;
    mn = 32'sh8000_0000;
    mxv = 32'sh7FFF_FFFF;
    calm = 1;
    send_planes(0, 0, 0, 0, 0, 0, 0, 0);
    send_planes(ONE, 2 * ONE, 3 * ONE, ONE, ONE, 2 * ONE, 3 * ONE, 5 * ONE);
    send_planes(ONE, 0, 0, -ONE, 0, ONE, 0, 2 * ONE);
    send_planes(0, ONE, 0, ONE, 0, 0, ONE, -3 * ONE);
    send_planes(0, 0, ONE, 7 * ONE, ONE, 0, 0, ONE);
    // ties: x with y, y with z, all three
    send_planes(0, 0, ONE, ONE, ONE, -ONE, 0, 2 * ONE);
    send_planes(ONE, 0, 0, 3 * ONE, 0, ONE, ONE, -ONE);
    send_planes(ONE, ONE, 0, ONE, 0, ONE, ONE, ONE);
    send_planes(mn, mn, mn, mn, mxv, mn, mxv, mxv);
    send_planes(mn, mxv, mn, mxv, mxv, mn, mn, mn);
    send_planes(mxv, mxv, mxv, mxv, mn, mxv, mn, mn);
    send_planes(mn, 0, 0, mn, 0, mn, 0, mxv);
    send_planes(1, 0, 0, mxv, 0, 1, 0, mn);
    send_planes(1, 0, 0, 0, 1, 1, 0, 0);
    send_planes(1, 0, 0, 5, 0, 4, 1, -5);
    send_planes(-1, -1, -1, -1, 1, 2, 3, 4);
    send_planes(ONE, 1, 0, mxv, 1, ONE, 0, mn);
    send_planes(2 * ONE, 4 * ONE, 6 * ONE, 0, -ONE, -2 * ONE, -3 * ONE, ONE);
    calm = 0;
  endtask

  task automatic test_limit_sweep();
    logic [62:0] settings[4];
    settings = '{63'd0, LIMIT_MAX, 63'd1 << 40, PARALLEL_LIMIT_RESET};
    foreach (settings[i]) begin
      write_limit(settings[i]);
      // exact zero cross product must stay non-unique even at limit zero
      send_planes(ONE, ONE, ONE, 0, -ONE, -ONE, -ONE, ONE);
      send_planes(1, 0, 0, 0, 1, 1, 0, 0);
      repeat (60) send_pair(rand_pair($urandom_range(0, 2)));
    end
  endtask

  task automatic test_backpressure();
    hold_req = 1;
    repeat (200) send_pair(rand_pair($urandom_range(0, 2)));
    hold_req = 0;
  endtask

  task automatic test_random();
    int kind;
    calm = 1;
    for (int n = 0; n < 1300; n++) begin
      if (n == 300) calm = 0;
      kind = $urandom_range(0, 9);
      send_pair(rand_pair(kind < 2 ? 0 : (kind < 4 ? 1 : 2)));
    end
    in_valid <= 1'b0;
  endtask

  initial begin
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_data     <= '0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    cur_limit   = PARALLEL_LIMIT_RESET;
    mismatches  = 0;
    words_sent  = 0;
    limit_writes = 0;
    calm        = 0;
    hold_req    = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_limit_sweep();
    test_backpressure();
    test_random();
    while (line_q.size() != 0) @(posedge clk);
    repeat (PIPE_DRAIN) @(posedge clk);
    $display("Sent %0d plane pairs, checked %0d words (%0d with a unique line).",
             words_sent, words_seen, unique_seen);
    $display("Limit written %0d times incl. zero and maximum; one long output hold.",
             limit_writes);
    if (mismatches == 0 && line_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // receiver: random stalls, one long hold while the sender keeps offering
  initial begin
    out_stall = 1'b0;
    hold_left = 0;
    hold_done = 0;
  end

  always @(posedge clk) begin
    if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
    out_stall <= (hold_left > 1) || (hold_req && !hold_done) ||
                 (!calm && $urandom_range(0, 99) < IDLE_PCT);
  end

  function automatic void check_field(input string nm, input logic [31:0] e, a);
    if (e !== a) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch word %0d %s: expected %h got %h", words_seen, nm, e, a);
    end
  endfunction

  initial begin
    words_seen = 0;
    unique_seen = 0;
  end

  always @(posedge clk) begin
    ppil_out_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (line_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %h", out_data);
      end else begin
        e = line_q.pop_front();
        check_field("unique_line", 32'(e.unique_line), 32'(out_data.unique_line));
        check_field("point_x", e.point_x, out_data.point_x);
        check_field("point_y", e.point_y, out_data.point_y);
        check_field("point_z", e.point_z, out_data.point_z);
        check_field("dir_x", e.dir_x, out_data.dir_x);
        check_field("dir_y", e.dir_y, out_data.dir_y);
        check_field("dir_z", e.dir_z, out_data.dir_z);
        if (e.unique_line) unique_seen++;
      end
      words_seen++;
    end
  end

  // watchdog: cycles without any accepted word
  initial quiet_cycles = 0;

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WDOG_LIMIT) begin
      $display("timeout: no word moved for %0d cycles", WDOG_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
